### sv/ccc_pkg.sv
package ccc_pkg;

	localparam int ACC_BITS_DEFAULT = 64;
	localparam int FIFO_AW          = 2;

	localparam int CUR_W    = 25;
	localparam int BUS_W    = 17;
	localparam int CHARGE_W = 53;

	localparam logic [1:0] REG_OFFSET   = 2'd0;
	localparam logic [1:0] REG_GAIN     = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	localparam logic signed [15:0] OFFSET_RESET   = 16'sd0;
	localparam logic [23:0]        GAIN_RESET     = 24'd65536;
	localparam logic [7:0]         INTERVAL_RESET = 8'd10;

	// x / 5 for x < 2^16 as (x * 52429) >> 18
	localparam logic [15:0] DIV5_RECIP = 16'd52429;
	localparam int          DIV5_SHIFT = 18;
	localparam int          GAIN_FRAC  = 16;

	localparam logic [12:0] CHARGE_DIV = 13'd3600;
	localparam int          DIV_RADIX_BITS = 4;

	typedef struct packed {
		logic signed [15:0] current_offset;
		logic [23:0]        current_gain;
		logic [7:0]         report_interval;
	} cfg_t;

	typedef struct packed {
		logic [CUR_W-1:0] calib_ma;
		logic [BUS_W-1:0] bus_mv;
		logic             report_due;
	} side_t;

endpackage

### sv/ccc_front.sv
module ccc_front #(
	parameter int ACCUMULATOR_BITS = ccc_pkg::ACC_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccc_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [15:0]                 current_word,
	input  logic [15:0]                 bus_word,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [ACCUMULATOR_BITS-1:0] q_acc,
	output ccc_pkg::side_t              q_side
);

	localparam int AB = ACCUMULATOR_BITS;
	localparam int CW = ccc_pkg::CUR_W;
	localparam int BW = ccc_pkg::BUS_W;

	logic en;
	assign en = !q_full;
	assign in_ready = en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic neg_s1;
	logic [15:0] mag_s1;
	logic [BW-1:0] bus_s1, bus_s2, bus_s3, bus_s4;
	logic [13:0] raw_s2;
	logic signed [16:0] diff_s3;
	logic signed [41:0] prod_s4;

	logic [AB-1:0] acc_q;
	logic [7:0] cnt_q;

	logic [18:0] bus_x5;
	logic [31:0] div5_p;
	logic [13:0] div5_q;

	assign bus_x5 = 19'(bus_word) + (19'(bus_word) << 2);
	assign div5_p = 32'(mag_s1) * 32'(ccc_pkg::DIV5_RECIP);
	assign div5_q = div5_p[ccc_pkg::DIV5_SHIFT +: 14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= current_word[15];
			mag_s1  <= current_word[15] ? 16'(~current_word + 16'd1) : current_word;
			bus_s1  <= bus_x5[18:2];
			// truncation toward zero: divide the magnitude, then restore the sign
			raw_s2  <= neg_s1 ? 14'(~div5_q + 14'd1) : div5_q;
			bus_s2  <= bus_s1;
			diff_s3 <= $signed({{3{raw_s2[13]}}, raw_s2})
				- $signed({cfg.current_offset[15], cfg.current_offset});
			bus_s3  <= bus_s2;
			prod_s4 <= $signed({{25{diff_s3[16]}}, diff_s3})
				* $signed({18'd0, cfg.current_gain});
			bus_s4  <= bus_s3;
		end
	end

	logic [CW-1:0] corr;
	logic [AB-1:0] acc_next;
	logic [7:0] cnt_inc, iv_eff;
	logic due;

	// low bits of prod >>> 16
	assign corr     = prod_s4[ccc_pkg::GAIN_FRAC +: CW];
	assign acc_next = acc_q + {{(AB-CW){corr[CW-1]}}, corr};
	assign cnt_inc  = cnt_q + 8'd1;
	assign iv_eff   = (cfg.report_interval == 8'd0) ? 8'd1 : cfg.report_interval;
	assign due      = (cnt_inc >= iv_eff) || (cnt_inc == 8'd0);

	assign q_push = v_s4 && en;
	assign q_acc  = acc_next;
	assign q_side.calib_ma   = corr;
	assign q_side.bus_mv     = bus_s4;
	assign q_side.report_due = due;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= 8'd0;
		end else if (q_push) begin
			acc_q <= acc_next;
			cnt_q <= due ? 8'd0 : cnt_inc;
		end
	end

endmodule

### sv/ccc_fifo.sv
module ccc_fifo #(
	parameter int W  = 8,
	parameter int AW = ccc_pkg::FIFO_AW
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0] count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/ccc_back.sv
module ccc_back #(
	parameter int ACCUMULATOR_BITS = ccc_pkg::ACC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [ACCUMULATOR_BITS-1:0]   q_acc,
	input  ccc_pkg::side_t                q_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ccc_pkg::side_t                out_side,
	output logic [ccc_pkg::CHARGE_W-1:0]  out_charge
);

	localparam int AB  = ACCUMULATOR_BITS;
	localparam int RB  = ccc_pkg::DIV_RADIX_BITS;
	localparam int NST = (AB + RB - 1) / RB;
	localparam int DW  = NST * RB;
	localparam int QW  = ccc_pkg::CHARGE_W;

	logic adv;
	logic out_valid_q;

	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && !q_empty;

	logic           val_s  [NST+1];
	logic           neg_s  [NST+1];
	ccc_pkg::side_t side_s [NST+1];
	logic [11:0]    rem_s  [NST+1];
	logic [DW-1:0]  work_s [NST+1];

	logic entry_neg;
	logic [AB-1:0] entry_mag;

	assign entry_neg = q_acc[AB-1];
	// most negative value gives 2^(AB-1), which is the right magnitude
	assign entry_mag = entry_neg ? (~q_acc + 1'b1) : q_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s[0] <= 1'b0;
		end else if (adv) begin
			val_s[0] <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[0]  <= entry_neg;
			side_s[0] <= q_side;
			rem_s[0]  <= 12'd0;
			work_s[0] <= DW'(entry_mag);
		end
	end

	// restoring division by 3600, RB quotient bits per stage, MSB first
	for (genvar k = 0; k < NST; k++) begin : g_div
		logic [11:0]   r;
		logic [DW-1:0] w;
		logic [12:0]   t;

		always_comb begin
			r = rem_s[k];
			w = work_s[k];
			t = '0;
			for (int j = 0; j < RB; j++) begin
				t = {r, w[DW-1]};
				w = {w[DW-2:0], 1'b0};
				if (t >= ccc_pkg::CHARGE_DIV) begin
					t = t - ccc_pkg::CHARGE_DIV;
					w[0] = 1'b1;
				end
				r = t[11:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k+1] <= 1'b0;
			end else if (adv) begin
				val_s[k+1] <= val_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= r;
				work_s[k+1] <= w;
			end
		end
	end

	logic [QW-1:0] quot;
	logic [QW-1:0] charge;

	assign quot   = QW'(work_s[NST]);
	assign charge = !side_s[NST].report_due ? '0 : (neg_s[NST] ? (~quot + 1'b1) : quot);

	ccc_pkg::side_t out_side_q;
	logic [QW-1:0] out_charge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= val_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_side_q   <= side_s[NST];
			out_charge_q <= charge;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_side   = out_side_q;
	assign out_charge = out_charge_q;

endmodule

### sv/calibrated_coulomb_counter.sv
// Calibrated coulomb counter. One sample per cycle is accepted while s_tready is high and one
// result per sample is returned, in order; with the output side ready the block sustains one
// transaction per clock. A sample passes through four front stages (magnitude, divide by five,
// offset, gain multiply), the accumulate on the way into the four-entry queue, the entry register
// from the queue into the divider, the signed divide by 3600 of the charge, which resolves four
// quotient bits per stage, and the output register. Back-pressure on the output fills the queue
// before the input side stalls. Configuration writes are taken at any clock with cfg_we high and
// must only be issued while no sample is in flight.
module calibrated_coulomb_counter #(
	parameter int ACCUMULATOR_BITS = ccc_pkg::ACC_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // current_word[15:0], bus_word[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // calib_ma[24:0], bus_mv[41:25], charge_tenth_mah[94:42]
	output logic [0:0]  m_tuser,   // report_due[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	localparam int AB = ACCUMULATOR_BITS;
	localparam int FW = AB + $bits(ccc_pkg::side_t);

	ccc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_offset  <= ccc_pkg::OFFSET_RESET;
			cfg_q.current_gain    <= ccc_pkg::GAIN_RESET;
			cfg_q.report_interval <= ccc_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ccc_pkg::REG_OFFSET:   cfg_q.current_offset  <= cfg_wdata[15:0];
				ccc_pkg::REG_GAIN:     cfg_q.current_gain    <= cfg_wdata;
				ccc_pkg::REG_INTERVAL: cfg_q.report_interval <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	logic q_full, q_empty, q_push, q_pop;
	logic [AB-1:0] push_acc;
	ccc_pkg::side_t push_side;
	logic [FW-1:0] q_rdata;

	ccc_front #(
		.ACCUMULATOR_BITS(AB)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.current_word (s_tdata[15:0]),
		.bus_word     (s_tdata[31:16]),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_acc        (push_acc),
		.q_side       (push_side)
	);

	ccc_fifo #(
		.W  (FW),
		.AW (ccc_pkg::FIFO_AW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({push_acc, push_side}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	ccc_pkg::side_t out_side;
	logic [ccc_pkg::CHARGE_W-1:0] out_charge;

	ccc_back #(
		.ACCUMULATOR_BITS(AB)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_acc      (q_rdata[FW-1 -: AB]),
		.q_side     (q_rdata[$bits(ccc_pkg::side_t)-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_side   (out_side),
		.out_charge (out_charge)
	);

	assign m_tdata = {1'b0, out_charge, out_side.bus_mv, out_side.calib_ma};
	assign m_tuser = out_side.report_due;

endmodule

### sim/testbench.sv
module testbench;

	localparam int PIPE_DEPTH = 23;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [24:0] calib_ma;
		logic [16:0] bus_mv;
		logic        report_due;
		logic [52:0] charge;
	} result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  index;
		logic [23:0] value;
		logic [15:0] cur;
		logic [15:0] bus;
		logic        typed;
		result_t     want;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;
	localparam int N_ROWS = 32;

	// rows marked typed carry their result; the rest go through predict_sample
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h0000, 16'h0000, 1'b1, '{25'd0, 17'd0, 1'b0, 53'd0}},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'hFFFF, 1'b1,
			'{-25'sd6553, 17'd81918, 1'b0, 53'd0}},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'h0004, 1'b1, '{25'd6553, 17'd5, 1'b0, 53'd0}},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h0005, 16'h0001, 1'b1, '{25'd1, 17'd1, 1'b0, 53'd0}},
		// -4/5 truncates to zero, not -1
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'hFFFC, 16'h0003, 1'b1, '{25'd0, 17'd3, 1'b0, 53'd0}},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h1234, 16'hAAAA, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'hEDCB, 16'h5555, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'hFFFF, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h4000, 16'h8000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'h0001, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8001, 16'h7FFF, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'hFFFF, 16'h00FF, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'hFF00, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h9999, 16'h1234, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'h0F0F, 1'b0, NO_RESULT},
		// interval dropped under the running count: next sample reports
		'{ROW_WRITE, ccc_pkg::REG_INTERVAL, 24'd3, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h0321, 16'hF0F0, 1'b0, NO_RESULT},
		// zero interval reports on every sample
		'{ROW_WRITE, ccc_pkg::REG_INTERVAL, 24'd0, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'h0002, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'hFFFE, 1'b0, NO_RESULT},
		'{ROW_WRITE, ccc_pkg::REG_OFFSET, 24'h008000, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, ccc_pkg::REG_GAIN, 24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'h0010, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'h0020, 1'b0, NO_RESULT},
		'{ROW_WRITE, ccc_pkg::REG_OFFSET, 24'h007FFF, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, ccc_pkg::REG_GAIN, 24'h000000, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h1234, 16'h4321, 1'b0, NO_RESULT},
		// unused index must leave every register alone
		'{ROW_WRITE, REG_NONE, 24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, ccc_pkg::REG_INTERVAL, 24'h0000FF, 16'h0000, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h8000, 16'hFFFF, 1'b0, NO_RESULT},
		'{ROW_SAMPLE, REG_NONE, 24'd0, 16'h7FFF, 16'h0000, 1'b0, NO_RESULT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // current_word[15:0], bus_word[31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [95:0] m_tdata;        // calib_ma[24:0], bus_mv[41:25], charge_tenth_mah[94:42]
	logic [0:0]  m_tuser;        // report_due[0]
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;

	// predictor state
	logic signed [15:0] cal_offset = ccc_pkg::OFFSET_RESET;
	logic [23:0]        cal_gain = ccc_pkg::GAIN_RESET;
	logic [7:0]         cal_interval = ccc_pkg::INTERVAL_RESET;
	longint             charge_acc = 0;
	logic [7:0]         samples_seen = '0;

	result_t expected_q[$];
	int      faults = 0;
	int      quiet = 0;
	int      ready_hold = 0;
	bit      burst_mode = 1'b0;

	calibrated_coulomb_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic result_t predict_sample(logic signed [15:0] cur, logic [15:0] bus);
		longint  amps;
		longint  prod;
		longint  corr;
		longint  tenths;
		logic [7:0] every;
		result_t r;
		amps = longint'(cur) / 5;
		prod = (amps - longint'(cal_offset)) * longint'(cal_gain);
		corr = prod >>> ccc_pkg::GAIN_FRAC;
		charge_acc = charge_acc + corr;
		samples_seen = samples_seen + 8'd1;
		every = (cal_interval == 8'd0) ? 8'd1 : cal_interval;
		r.calib_ma = corr[24:0];
		r.bus_mv = 17'((32'(bus) * 5) / 4);
		r.report_due = 1'b0;
		r.charge = '0;
		if (samples_seen >= every || samples_seen == 8'd0) begin
			r.report_due = 1'b1;
			samples_seen = '0;
			tenths = charge_acc / 3600;
			r.charge = tenths[52:0];
		end
		return r;
	endfunction

	function automatic logic [23:0] pick_cfg(logic [1:0] idx);
		case (idx)
			ccc_pkg::REG_OFFSET: begin
				case ($urandom_range(0, 4))
					0: return 24'h008000;
					1: return 24'h007FFF;
					2: return 24'h000000;
					3: return 24'(16'($urandom_range(0, 200) - 100));
					default: return 24'($urandom);
				endcase
			end
			ccc_pkg::REG_GAIN: begin
				case ($urandom_range(0, 4))
					0: return 24'h000000;
					1: return 24'hFFFFFF;
					2: return 24'd65536;
					3: return 24'($urandom_range(32768, 98304));
					default: return 24'($urandom);
				endcase
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 24'd0;
					1: return 24'd1;
					2: return 24'd255;
					3: return 24'($urandom_range(1, 16));
					default: return 24'($urandom_range(0, 255));
				endcase
			end
		endcase
	endfunction

	// registers only change once every result has drained
	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ccc_pkg::REG_OFFSET:   cal_offset = val[15:0];
			ccc_pkg::REG_GAIN:     cal_gain = val;
			ccc_pkg::REG_INTERVAL: cal_interval = val[7:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(logic [15:0] cur, logic [15:0] bus, result_t want);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bus, cur};
		expected_q.push_back(want);
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		stim_row_t   row;
		result_t     pred;
		logic [15:0] cur;
		logic [15:0] bus;
		int          count;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_WRITE) begin
				write_reg(row.index, row.value);
			end else begin
				pred = predict_sample(row.cur, row.bus);
				send_sample(row.cur, row.bus, row.typed ? row.want : pred);
			end
		end

		for (int phase = 0; phase < 10; phase++) begin
			write_reg(ccc_pkg::REG_OFFSET, pick_cfg(ccc_pkg::REG_OFFSET));
			write_reg(ccc_pkg::REG_GAIN, pick_cfg(ccc_pkg::REG_GAIN));
			// first phase is long enough to reach a report at the widest interval
			write_reg(ccc_pkg::REG_INTERVAL,
				phase == 0 ? 24'd255 : pick_cfg(ccc_pkg::REG_INTERVAL));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, 24'($urandom));
			count = (phase == 0) ? 300 : $urandom_range(60, 120);
			for (int n = 0; n < count; n++) begin
				if (n % 40 == 0)
					burst_mode = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 9))
					0: cur = 16'h8000;
					1: cur = 16'h7FFF;
					2: cur = 16'($urandom_range(0, 40) - 20);
					default: cur = 16'($urandom);
				endcase
				bus = 16'($urandom);
				pred = predict_sample(cur, bus);
				send_sample(cur, bus, pred);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (faults == 0 && expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side may stall for a random number of cycles after each transaction
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			if (ready_hold == 0)
				m_tready <= 1'b1;
		end else if (arst_n && m_tvalid && m_tready) begin
			ready_hold = draw_gap();
			if (ready_hold > 0)
				m_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.calib_ma = m_tdata[24:0];
			got.bus_mv = m_tdata[41:25];
			got.charge = m_tdata[94:42];
			got.report_due = m_tuser[0];
			if (expected_q.size() == 0) begin
				if (faults < 10)
					$display("unexpected result: cur=%0d bus=%0d due=%0b charge=%0d",
						$signed(got.calib_ma), got.bus_mv, got.report_due,
						$signed(got.charge));
				faults++;
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					if (faults < 10)
						$display("bad result: cur %0d/%0d bus %0d/%0d due %0b/%0b charge %0d/%0d",
							$signed(want.calib_ma), $signed(got.calib_ma),
							want.bus_mv, got.bus_mv, want.report_due, got.report_due,
							$signed(want.charge), $signed(got.charge));
					faults++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

### sim.f
sv/ccc_pkg.sv
sv/ccc_front.sv
sv/ccc_fifo.sv
sv/ccc_back.sv
sv/calibrated_coulomb_counter.sv
sim/testbench.sv
